[design/stt_pkg.sv]
// Shared types and constants for the source text tokenizer.
`default_nettype none

package stt_pkg;

    localparam int LINE_BITS   = 24;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = ((8 + LINE_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W   = 4;

    typedef enum logic [1:0] {
        KIND_WS     = 2'd0,
        KIND_IDENT  = 2'd1,
        KIND_STRING = 2'd2
    } stt_kind_t;

    typedef enum logic [1:0] {
        EV_FIRST = 2'd0,
        EV_MORE  = 2'd1,
        EV_END   = 2'd2
    } stt_event_t;

    typedef struct packed {
        stt_kind_t            kind;
        stt_event_t           code;
        logic [7:0]           tbyte;
        logic [LINE_BITS-1:0] line;
    } stt_result_t;

    // All results caused by one input byte; cnt is 1 to 3 once queued.
    typedef struct packed {
        logic [1:0]            cnt;
        stt_result_t [2:0]     res;
    } stt_bundle_t;

    function automatic stt_result_t make_res(stt_kind_t kind, stt_event_t code,
                                             logic [7:0] tbyte,
                                             logic [LINE_BITS-1:0] line);
        stt_result_t r;
        r.kind  = kind;
        r.code  = code;
        r.tbyte = tbyte;
        r.line  = line;
        return r;
    endfunction

endpackage

`default_nettype wire

[design/stt_front.sv]
// Scanner front end: classifies each byte and forms its bundle of results.
`default_nettype none

module stt_front
    import stt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_final,
    output logic             push,
    output stt_bundle_t      push_data
);

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef enum logic [2:0] {
        M_IDLE       = 3'd0,
        M_IDENT      = 3'd1,
        M_STR_EMPTY  = 3'd2,
        M_STR_BODY   = 3'd3,
        M_SLASH      = 3'd4,
        M_BLOCK      = 3'd5,
        M_BLOCK_STAR = 3'd6,
        M_LINE       = 3'd7
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    stt_result_t [2:0]    res;
    logic [1:0]           n;
    logic                 do_idle;

    function automatic logic is_ws(logic [7:0] b);
        return b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB;
    endfunction

    function automatic logic ident_start(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               b[7] || b == CH_USCORE;
    endfunction

    function automatic logic ident_more(logic [7:0] b);
        return ident_start(b) || (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic [LINE_BITS-1:0] bump(logic [LINE_BITS-1:0] l);
        return (l == LINE_MAX) ? l : l + 1'b1;
    endfunction

    always_comb begin
        res       = '0;
        n         = 2'd0;
        mode_next = mode_reg;
        line_next = line_reg;
        do_idle   = 1'b0;

        case (mode_reg)
            M_IDENT: begin
                if (ident_more(in_byte)) begin
                    res[n] = make_res(KIND_IDENT, EV_MORE, in_byte, line_next);
                    n      = n + 2'd1;
                end else begin
                    res[n]  = make_res(KIND_IDENT, EV_END, 8'h00, line_next);
                    n       = n + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_STR_EMPTY, M_STR_BODY: begin
                if (in_byte == CH_QUOTE) begin
                    res[n]    = make_res(KIND_STRING, EV_END, 8'h00, line_next);
                    n         = n + 2'd1;
                    mode_next = M_IDLE;
                end else begin
                    res[n]    = make_res(KIND_STRING,
                                         (mode_reg == M_STR_EMPTY) ? EV_FIRST : EV_MORE,
                                         in_byte, line_next);
                    n         = n + 2'd1;
                    mode_next = M_STR_BODY;
                end
            end
            M_SLASH: begin
                if (in_byte == CH_STAR) begin
                    mode_next = M_BLOCK;
                end else if (in_byte == CH_SLASH) begin
                    mode_next = M_LINE;
                end else begin
                    do_idle = 1'b1;
                end
            end
            M_BLOCK: begin
                if (in_byte == CH_STAR) begin
                    mode_next = M_BLOCK_STAR;
                end else if (in_byte == CH_LF) begin
                    line_next = bump(line_next);
                end
            end
            M_BLOCK_STAR: begin
                if (in_byte == CH_SLASH) begin
                    mode_next = M_IDLE;
                end else if (in_byte != CH_STAR) begin
                    if (in_byte == CH_LF) begin
                        line_next = bump(line_next);
                    end
                    mode_next = M_BLOCK;
                end
            end
            M_LINE: begin
                if (in_byte == CH_LF) begin
                    line_next = bump(line_next);
                    mode_next = M_IDLE;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // Start over from idle with the same byte.
        if (do_idle) begin
            mode_next = M_IDLE;
            if (is_ws(in_byte)) begin
                if (in_byte == CH_LF) begin
                    line_next = bump(line_next);
                end
                res[n] = make_res(KIND_WS, EV_FIRST, in_byte, line_next);
                n      = n + 2'd1;
                res[n] = make_res(KIND_WS, EV_END, 8'h00, line_next);
                n      = n + 2'd1;
            end else if (in_byte == CH_SLASH) begin
                mode_next = M_SLASH;
            end else if (in_byte == CH_QUOTE) begin
                mode_next = M_STR_EMPTY;
            end else if (ident_start(in_byte)) begin
                res[n]    = make_res(KIND_IDENT, EV_FIRST, in_byte, line_next);
                n         = n + 2'd1;
                mode_next = M_IDENT;
            end
        end

        // End of file closes any open token.
        if (in_final) begin
            if (mode_next == M_IDENT) begin
                res[n] = make_res(KIND_IDENT, EV_END, 8'h00, line_next);
                n      = n + 2'd1;
            end else if (mode_next == M_STR_EMPTY || mode_next == M_STR_BODY) begin
                res[n] = make_res(KIND_STRING, EV_END, 8'h00, line_next);
                n      = n + 2'd1;
            end
            mode_next = M_IDLE;
        end
    end

    assign push          = in_accept && (n != 2'd0);
    assign push_data.cnt = n;
    assign push_data.res = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            line_reg <= LINE_BITS'(1);
        end else if (in_accept) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line counter reached zero");
`endif

endmodule

`default_nettype wire

[design/stt_queue.sv]
// Short queue of result bundles between scanner and output sequencer.
`default_nettype none

module stt_queue
    import stt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire stt_bundle_t  push_data,
    input  wire logic         pop,
    output stt_bundle_t       pop_data,
    output logic              full,
    output logic              empty
);

    stt_bundle_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   cnt_reg, cnt_next;

    function automatic logic [QPTR_BITS-1:0] wrap_inc(logic [QPTR_BITS-1:0] p);
        return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = cnt_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

[design/stt_back.sv]
// Output sequencer: sends the results of each bundle one per cycle while m_tready is high.
`default_nettype none

module stt_back
    import stt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_empty,
    input  wire stt_bundle_t           q_data,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [M_TUSER_W-1:0]       m_tuser,
    output logic                       m_tlast
);

    stt_bundle_t  bundle_reg;
    logic [1:0]   idx_reg;
    logic         valid_reg;
    logic         last;
    stt_result_t  cur;

    assign cur  = bundle_reg.res[idx_reg];
    assign last = idx_reg == (bundle_reg.cnt - 2'd1);
    assign pop  = !q_empty && (!valid_reg || (m_tready && last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_tready) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            bundle_reg <= q_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'({cur.line, cur.tbyte});
    assign m_tuser  = {cur.code, cur.kind};
    assign m_tlast  = last;

`ifndef NO_ASSERTIONS
    a_idx_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (idx_reg < bundle_reg.cnt))
        else $error("result index beyond bundle");
`endif

endmodule

`default_nettype wire

[design/source_text_tokenizer_unit.sv]
// Source text tokenizer top level: scanner, bundle queue and output sequencer.
//
// Usage:
//   Source bytes arrive on the s_ stream, one request per byte; s_tlast marks
//   the last byte of a file and closes any open identifier or string.
//   Token events leave on the m_ stream, one request per event; m_tlast marks
//   the last event caused by a given input byte.
//   A byte causes zero to three events. The scanner handles one byte per
//   cycle while the queue has room and writes that byte's events as one bundle
//   into a four-entry queue at the edge that accepts the byte. The sequencer
//   pops a bundle once it is done with the previous one and drains it at one
//   event per cycle while m_tready is high. Sustained input rate is one byte
//   per cycle while bytes average at most one event each and m_tready stays
//   high; the single event output port sets the limit.
//   When the receiver stalls, the current event holds on m_ and the queue
//   fills; s_tready drops once all four queue entries are taken.
//   Reset (aresetn low at a clock edge) empties the queue, drops any pending
//   event and returns the scanner to idle with the line count at one.
`default_nettype none

module source_text_tokenizer_unit
    import stt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] text_byte
    input  wire logic                  s_tlast,   // final_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [7:0] token_byte, [31:8] line_number
    output logic [M_TUSER_W-1:0]       m_tuser,   // [1:0] token_kind, [3:2] event_code
    output logic                       m_tlast    // last_of_run
);

    logic        in_accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    stt_bundle_t push_data;
    stt_bundle_t q_data;

    // Take a byte whenever the queue has room for its bundle.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    stt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata[7:0]),
        .in_final  (s_tlast),
        .push      (push),
        .push_data (push_data)
    );

    stt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    stt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
